>>> design/pac_pkg.sv
// ----------------------------------------------------------------------------
// Projected area accumulator package
// Shared constants, payload types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_MAX   = 24;
  localparam int CORDIC_ITERS = (ANGLE_BITS < CORDIC_MAX) ? ANGLE_BITS : CORDIC_MAX;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int ATAN_IDX_W   = 5;

  // Datapath width of the CORDIC, signed Q2.30 with headroom.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic [17:0]          PI_Q16   = 18'd205887;

  typedef logic [15:0] mag_t;
  typedef logic [15:0] dim_t;
  typedef logic [15:0] angle_t;
  typedef logic signed [15:0] elev_t;

  typedef enum logic [1:0] {
    PRIM_BOX    = 2'd0,
    PRIM_CYL    = 2'd1,
    PRIM_SPHERE = 2'd2,
    PRIM_PANEL  = 2'd3
  } prim_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    mag_t sin_mag;
    mag_t cos_mag;
  } cordic_res_t;

  function automatic logic [29:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/pac_in_if.sv
// ----------------------------------------------------------------------------
// Primitive input channel
// Valid/ready channel carrying one primitive and its view direction.
// ----------------------------------------------------------------------------
interface pac_in_if;
  import pac_pkg::*;

  logic   valid;
  logic   ready;
  angle_t az;
  elev_t  el;
  prim_t  prim_type;
  dim_t   dim_x;
  dim_t   dim_y;
  dim_t   dim_z;
  logic   last_prim;
  logic   restart_stats;

  modport source (
    output valid, az, el, prim_type, dim_x, dim_y, dim_z, last_prim, restart_stats,
    input  ready
  );

  modport sink (
    input  valid, az, el, prim_type, dim_x, dim_y, dim_z, last_prim, restart_stats,
    output ready
  );

endinterface

>>> design/pac_out_if.sv
// ----------------------------------------------------------------------------
// Direction result channel
// Valid/ready channel carrying one direction total and the running statistics.
// ----------------------------------------------------------------------------
interface pac_out_if;
  import pac_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] direction_area;
  logic [31:0] max_area;
  logic [31:0] min_area;
  logic [47:0] area_sum;
  logic [15:0] sample_count;

  modport source (
    output valid, direction_area, max_area, min_area, area_sum, sample_count,
    input  ready
  );

  modport sink (
    input  valid, direction_area, max_area, min_area, area_sum, sample_count,
    output ready
  );

endinterface

>>> design/pac_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// Rotation-mode CORDIC, one micro-rotation per cycle, returning the rounded
// Q1.15 magnitudes of sine and cosine of a 32-bit binary angle. A new request
// is taken in the idle state or in the cycle that reports done.
// ----------------------------------------------------------------------------
module pac_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pac_pkg::cordic_req_t req,
  output pac_pkg::cordic_res_t res
);
  import pac_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_DONE = 3'b100
  } cstate_t;

  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [CW-1:0] Q15_HALF     = 34'sd16384;
  localparam logic signed [CW-1:0] Q15_ONE      = 34'sd32768;

  cstate_t state_r, state_nxt;

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [ITER_W-1:0]    iter_r;

  logic signed [CW-1:0] z_in, z_fold;
  logic signed [CW-1:0] x_sh, y_sh, at;
  logic                 last_iter;

  function automatic mag_t to_mag(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] a;
    r = (v + Q15_HALF) >>> 15;
    a = r[CW-1] ? -r : r;
    return (a > Q15_ONE) ? Q15_ONE[15:0] : a[15:0];
  endfunction

  // Angles beyond a quarter turn are folded by a half turn; only the
  // magnitudes leave this unit, so the sign flip is not needed.
  always_comb begin
    z_in = {{(CW-32){req.angle[31]}}, req.angle};
    if (z_in > QUARTER_TURN) begin
      z_fold = z_in - HALF_TURN;
    end else if (z_in < -QUARTER_TURN) begin
      z_fold = z_in + HALF_TURN;
    end else begin
      z_fold = z_in;
    end
  end

  assign x_sh      = x_r >>> iter_r;
  assign y_sh      = y_r >>> iter_r;
  assign at        = {{(CW-30){1'b0}}, atan_turn(ATAN_IDX_W'(iter_r))};
  assign last_iter = (iter_r == ITER_W'(CORDIC_ITERS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: begin
        if (req.start) begin
          state_nxt = C_RUN;
        end
      end
      C_RUN: begin
        if (last_iter) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        if (req.start) begin
          state_nxt = C_RUN;
        end else begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r inside {C_IDLE, C_DONE}) && req.start) begin
      x_r    <= CORDIC_K;
      y_r    <= '0;
      z_r    <= z_fold;
      iter_r <= '0;
    end else if (state_r == C_RUN) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + at;
      end
      if (!last_iter) begin
        iter_r <= iter_r + 1'b1;
      end
    end
  end

  assign res.done    = (state_r == C_DONE);
  assign res.cos_mag = to_mag(x_r);
  assign res.sin_mag = to_mag(y_r);

endmodule

>>> design/projected_area_accumulator.sv
// ----------------------------------------------------------------------------
// Projected area accumulator
// Adds the projected areas of box, cylinder, sphere and panel primitives for
// one view direction and reports the total with running statistics.
// ----------------------------------------------------------------------------
// The block takes one primitive at a time and is not ready while it works on
// it. Each primitive takes one CORDIC pass for the azimuth and another for
// the elevation, then eight steps of the shared 32 by 18 bit multiplier (four
// for a sphere or a panel), then the round and accumulate states and a return
// to idle. A result transaction is produced only for the primitive marked
// last_prim, and it waits in an output register, so the next primitive is
// accepted while the result is still pending; a further last primitive holds
// in its accumulate state until that register is free. Areas and sums
// saturate instead of wrapping.
// ----------------------------------------------------------------------------
module projected_area_accumulator (
  input  logic clk,
  input  logic rst_n,
  pac_in_if.sink    in_chan,
  pac_out_if.source out_chan
);
  import pac_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_AZ    = 6'b000010,
    S_EL    = 6'b000100,
    S_MUL   = 6'b001000,
    S_ROUND = 6'b010000,
    S_ACCUM = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    A_CE, A_DX, A_DY, A_T_LO, A_T_HI
  } a_sel_t;

  typedef enum logic [3:0] {
    B_CAZ, B_SAZ, B_DX, B_DY, B_DZ, B_NX, B_NY, B_NZ, B_CE, B_PI
  } b_sel_t;

  typedef enum logic [2:0] {
    D_NX, D_NY, D_T, D_T_PI, D_ACC0, D_ACC16, D_ACC32
  } dst_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    logic   last;
  } step_op_t;

  localparam int RND_BOX    = 23;
  localparam int RND_CYL    = 39;
  localparam int RND_SPHERE = 26;

  state_t state_r, state_nxt;

  prim_t       prim_type_r;
  dim_t        dx_r, dy_r, dz_r;
  elev_t       el_r;
  logic        last_r, restart_r;
  mag_t        caz_r, saz_r, ce_r, nz_r, nx_r, ny_r;
  logic [2:0]  step_r;
  logic [47:0] t_r;
  logic [63:0] acc_r;
  logic [31:0] area_r;

  logic [31:0] partial_r, max_r, min_r, out_area_r;
  logic [47:0] sum_r;
  logic [15:0] cnt_r;
  logic        out_valid_r;

  cordic_req_t creq;
  cordic_res_t cres;

  step_op_t    op;
  logic [31:0] mul_a;
  logic [17:0] mul_b;
  logic [49:0] prod;

  logic [64:0] rnd;
  logic [31:0] area_sat;
  logic [32:0] total_sum;
  logic [31:0] total;
  logic [31:0] eff_max, eff_min, new_max, new_min;
  logic [47:0] eff_sum, new_sum;
  logic [48:0] sum_ext;
  logic [15:0] eff_cnt, new_cnt;
  logic        in_accept, out_free, emit;

  function automatic step_op_t decode_step(input prim_t pt, input logic [2:0] st);
    step_op_t o;
    o = '{a_sel: A_CE, b_sel: B_CAZ, dst: D_NX, last: 1'b0};
    if (st == 3'd0) begin
      o = '{a_sel: A_CE, b_sel: B_CAZ, dst: D_NX, last: 1'b0};
    end else if (st == 3'd1) begin
      o = '{a_sel: A_CE, b_sel: B_SAZ, dst: D_NY, last: 1'b0};
    end else begin
      case (pt)
        PRIM_BOX: begin
          case (st)
            3'd2:    o = '{a_sel: A_DY,   b_sel: B_DZ, dst: D_T,    last: 1'b0};
            3'd3:    o = '{a_sel: A_T_LO, b_sel: B_NX, dst: D_ACC0, last: 1'b0};
            3'd4:    o = '{a_sel: A_DX,   b_sel: B_DZ, dst: D_T,    last: 1'b0};
            3'd5:    o = '{a_sel: A_T_LO, b_sel: B_NY, dst: D_ACC0, last: 1'b0};
            3'd6:    o = '{a_sel: A_DX,   b_sel: B_DY, dst: D_T,    last: 1'b0};
            default: o = '{a_sel: A_T_LO, b_sel: B_NZ, dst: D_ACC0, last: 1'b1};
          endcase
        end
        PRIM_CYL: begin
          case (st)
            3'd2:    o = '{a_sel: A_DX,   b_sel: B_DX, dst: D_T,     last: 1'b0};
            3'd3:    o = '{a_sel: A_T_LO, b_sel: B_PI, dst: D_T_PI,  last: 1'b0};
            3'd4:    o = '{a_sel: A_T_LO, b_sel: B_NZ, dst: D_ACC0,  last: 1'b0};
            3'd5:    o = '{a_sel: A_T_HI, b_sel: B_NZ, dst: D_ACC32, last: 1'b0};
            3'd6:    o = '{a_sel: A_DX,   b_sel: B_DY, dst: D_T,     last: 1'b0};
            default: o = '{a_sel: A_T_LO, b_sel: B_CE, dst: D_ACC16, last: 1'b1};
          endcase
        end
        PRIM_SPHERE: begin
          case (st)
            3'd2:    o = '{a_sel: A_DX,   b_sel: B_DX, dst: D_T,    last: 1'b0};
            default: o = '{a_sel: A_T_LO, b_sel: B_PI, dst: D_ACC0, last: 1'b1};
          endcase
        end
        default: begin
          case (st)
            3'd2:    o = '{a_sel: A_DX,   b_sel: B_DY, dst: D_T,    last: 1'b0};
            default: o = '{a_sel: A_T_LO, b_sel: B_NZ, dst: D_ACC0, last: 1'b1};
          endcase
        end
      endcase
    end
    return o;
  endfunction

  pac_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .res   (cres)
  );

  assign in_accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    creq.start = (state_r == S_IDLE && in_accept) || (state_r == S_AZ && cres.done);
    creq.angle = (state_r == S_IDLE) ? {in_chan.az, 16'd0} : {el_r, 16'd0};
  end

  // Shared multiplier.
  assign op = decode_step(prim_type_r, step_r);

  always_comb begin
    case (op.a_sel)
      A_CE:    mul_a = {16'd0, ce_r};
      A_DX:    mul_a = {16'd0, dx_r};
      A_DY:    mul_a = {16'd0, dy_r};
      A_T_LO:  mul_a = t_r[31:0];
      A_T_HI:  mul_a = {16'd0, t_r[47:32]};
      default: mul_a = '0;
    endcase
    case (op.b_sel)
      B_CAZ:   mul_b = {2'd0, caz_r};
      B_SAZ:   mul_b = {2'd0, saz_r};
      B_DX:    mul_b = {2'd0, dx_r};
      B_DY:    mul_b = {2'd0, dy_r};
      B_DZ:    mul_b = {2'd0, dz_r};
      B_NX:    mul_b = {2'd0, nx_r};
      B_NY:    mul_b = {2'd0, ny_r};
      B_NZ:    mul_b = {2'd0, nz_r};
      B_CE:    mul_b = {2'd0, ce_r};
      B_PI:    mul_b = PI_Q16;
      default: mul_b = '0;
    endcase
  end

  assign prod = {18'd0, mul_a} * {32'd0, mul_b};

  // Rounding to Q24.8 with saturation.
  always_comb begin
    case (prim_type_r)
      PRIM_CYL:    rnd = ({1'b0, acc_r} + (65'd1 << (RND_CYL - 1))) >> RND_CYL;
      PRIM_SPHERE: rnd = ({1'b0, acc_r} + (65'd1 << (RND_SPHERE - 1))) >> RND_SPHERE;
      default:     rnd = ({1'b0, acc_r} + (65'd1 << (RND_BOX - 1))) >> RND_BOX;
    endcase
    area_sat = (|rnd[64:32]) ? '1 : rnd[31:0];
  end

  // Direction total and statistics update.
  always_comb begin
    total_sum = {1'b0, partial_r} + {1'b0, area_r};
    total     = total_sum[32] ? '1 : total_sum[31:0];
    eff_max   = restart_r ? '0 : max_r;
    eff_min   = restart_r ? '1 : min_r;
    eff_sum   = restart_r ? '0 : sum_r;
    eff_cnt   = restart_r ? '0 : cnt_r;
    new_max   = (total > eff_max) ? total : eff_max;
    new_min   = (total < eff_min) ? total : eff_min;
    sum_ext   = {1'b0, eff_sum} + {17'd0, total};
    new_sum   = sum_ext[48] ? '1 : sum_ext[47:0];
    new_cnt   = (eff_cnt != '1) ? eff_cnt + 16'd1 : eff_cnt;
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign emit     = (state_r == S_ACCUM) && last_r && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_AZ;
        end
      end
      S_AZ: begin
        if (cres.done) begin
          state_nxt = S_EL;
        end
      end
      S_EL: begin
        if (cres.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (op.last) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_ACCUM;
      S_ACCUM: begin
        if (!last_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      partial_r   <= '0;
      max_r       <= '0;
      min_r       <= '1;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_ACCUM) begin
        if (!last_r) begin
          partial_r <= total;
        end else if (out_free) begin
          partial_r <= '0;
          max_r     <= new_max;
          min_r     <= new_min;
          sum_r     <= new_sum;
          cnt_r     <= new_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      prim_type_r <= in_chan.prim_type;
      dx_r        <= in_chan.dim_x;
      dy_r        <= in_chan.dim_y;
      dz_r        <= in_chan.dim_z;
      el_r        <= in_chan.el;
      last_r      <= in_chan.last_prim;
      restart_r   <= in_chan.restart_stats;
    end
    if (state_r == S_AZ && cres.done) begin
      caz_r <= cres.cos_mag;
      saz_r <= cres.sin_mag;
    end
    if (state_r == S_EL && cres.done) begin
      ce_r   <= cres.cos_mag;
      nz_r   <= cres.sin_mag;
      acc_r  <= '0;
      step_r <= '0;
    end
    if (state_r == S_MUL) begin
      step_r <= step_r + 3'd1;
      case (op.dst)
        D_NX:    nx_r  <= 16'(({1'b0, prod[31:0]} + 33'd16384) >> 15);
        D_NY:    ny_r  <= 16'(({1'b0, prod[31:0]} + 33'd16384) >> 15);
        D_T:     t_r   <= prod[47:0];
        D_T_PI:  t_r   <= prod[49:2];
        D_ACC0:  acc_r <= acc_r + {14'd0, prod};
        D_ACC16: acc_r <= acc_r + {prod[47:0], 16'd0};
        D_ACC32: acc_r <= acc_r + {prod[31:0], 32'd0};
        default: acc_r <= acc_r;
      endcase
    end
    if (state_r == S_ROUND) begin
      area_r <= area_sat;
    end
    if (emit) begin
      out_area_r <= total;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.direction_area = out_area_r;
  assign out_chan.max_area       = max_r;
  assign out_chan.min_area       = min_r;
  assign out_chan.area_sum       = sum_r;
  assign out_chan.sample_count   = cnt_r;

endmodule

>>> tb/sv/tb_projected_area_accumulator.sv
// ----------------------------------------------------------------------------
// Projected area accumulator testbench
// Sends primitives over the input channel under random bursts and output
// stalls, predicts every direction total and its running statistics with a
// behavioral CORDIC and area model, and checks each result transaction.
// ----------------------------------------------------------------------------
module tb_projected_area_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import pac_pkg::*;

  localparam int     HALF_PERIOD      = 4;
  localparam int     RESET_CYCLES     = 8;
  localparam int     DRAIN_CYCLES     = 200;
  localparam int     MAX_REPORTS      = 10;
  localparam int     SATURATION_PRIMS = 160;
  localparam int     TIMEOUT_NS       = 8_000_000;
  localparam int     ROTATIONS        = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;
  localparam longint CORDIC_GAIN      = 64'sd652032874;
  localparam longint QUARTER_TURN     = 64'sd1073741824;
  localparam longint HALF_TURN        = 64'sd2147483648;
  localparam logic [63:0] PI_Q2_16    = 64'd205887;
  localparam logic [63:0] SUM_CEILING = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    angle_t az;
    elev_t  el;
    prim_t  kind;
    dim_t   dim_x;
    dim_t   dim_y;
    dim_t   dim_z;
    logic   last_prim;
    logic   restart_stats;
  } prim_item_t;

  typedef struct {
    logic [31:0] direction_area;
    logic [31:0] max_area;
    logic [31:0] min_area;
    logic [47:0] area_sum;
    logic [15:0] sample_count;
  } direction_report_t;

  logic clk = 1'b0;
  logic rst_n;

  pac_in_if  prim_chan();
  pac_out_if result_chan();

  projected_area_accumulator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (prim_chan),
    .out_chan (result_chan)
  );

  always #(HALF_PERIOD) clk = ~clk;

  longint arctan_step [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  logic [31:0] partial_area;
  logic [31:0] stat_max;
  logic [31:0] stat_min;
  logic [47:0] stat_sum;
  logic [15:0] stat_count;

  direction_report_t direction_results_q [$];
  direction_report_t got;
  direction_report_t want;

  int  mismatch_count = 0;
  int  prims_sent;
  int  totals_checked = 0;
  int  restarts_seen;
  int  saturated_totals;
  int  burst_left;
  bit  sender_gaps_on;
  bit  receiver_stalls_on;

  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_phase = 4'd0;

  function automatic int round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic void rotate_angle(input logic [15:0] angle, output int sin_q15,
                                       output int cos_q15);
    longint x;
    longint y;
    longint z;
    longint step_x;
    longint step_y;
    logic   flip;
    z = longint'($signed({angle, 16'h0000}));
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      step_x = y >>> i;
      step_y = x >>> i;
      if (z >= 0) begin
        x -= step_x;
        y += step_y;
        z -= arctan_step[i];
      end else begin
        x += step_x;
        y -= step_y;
        z += arctan_step[i];
      end
    end
    cos_q15 = round_q15(x);
    sin_q15 = round_q15(y);
    if (flip) begin
      cos_q15 = -cos_q15;
      sin_q15 = -sin_q15;
    end
  endfunction

  function automatic logic [63:0] magnitude(input int v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] scale_q15(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd16384) >> 15;
  endfunction

  function automatic logic [31:0] saturate32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] primitive_area(input prim_item_t it, input logic [63:0] nx,
                                                 input logic [63:0] ny, input logic [63:0] nz,
                                                 input logic [63:0] ce);
    logic [63:0] lx;
    logic [63:0] ly;
    logic [63:0] lz;
    logic [63:0] acc;
    lx = 64'(it.dim_x);
    ly = 64'(it.dim_y);
    lz = 64'(it.dim_z);
    case (it.kind)
      PRIM_BOX: begin
        acc = (ly * lz * nx + lx * lz * ny + lx * ly * nz + (64'd1 << 22)) >> 23;
      end
      PRIM_CYL: begin
        acc = ((((lx * lx * PI_Q2_16) >> 2) * nz) + ((lx * ly * ce) << 16));
        acc = (acc + (64'd1 << 38)) >> 39;
      end
      PRIM_SPHERE: begin
        acc = (lx * lx * PI_Q2_16 + (64'd1 << 25)) >> 26;
      end
      default: begin
        acc = (lx * ly * nz + (64'd1 << 22)) >> 23;
      end
    endcase
    return saturate32(acc);
  endfunction

  function automatic void accumulate_primitive(input prim_item_t it);
    int                sin_az;
    int                cos_az;
    int                sin_el;
    int                cos_el;
    logic [63:0]       ce;
    logic [63:0]       nx;
    logic [63:0]       ny;
    logic [63:0]       nz;
    logic [63:0]       sum_next;
    logic [31:0]       total;
    direction_report_t report;
    rotate_angle(it.az, sin_az, cos_az);
    rotate_angle(it.el, sin_el, cos_el);
    ce = magnitude(cos_el);
    nx = scale_q15(ce, magnitude(cos_az));
    ny = scale_q15(ce, magnitude(sin_az));
    nz = magnitude(sin_el);
    total = saturate32(64'(partial_area) + 64'(primitive_area(it, nx, ny, nz, ce)));
    if (!it.last_prim) begin
      partial_area = total;
      return;
    end
    partial_area = '0;
    if (it.restart_stats) begin
      stat_max = '0;
      stat_min = '1;
      stat_sum = '0;
      stat_count = '0;
      restarts_seen++;
    end
    if (total > stat_max) stat_max = total;
    if (total < stat_min) stat_min = total;
    sum_next = 64'(stat_sum) + 64'(total);
    stat_sum = (sum_next > SUM_CEILING) ? SUM_CEILING[47:0] : sum_next[47:0];
    if (stat_count != 16'hFFFF) stat_count++;
    if (total == 32'hFFFF_FFFF) saturated_totals++;
    report.direction_area = total;
    report.max_area = stat_max;
    report.min_area = stat_min;
    report.area_sum = stat_sum;
    report.sample_count = stat_count;
    direction_results_q = {direction_results_q, report};
  endfunction

  function automatic prim_item_t prim(input angle_t az, input elev_t el, input prim_t kind,
                                      input dim_t dx, input dim_t dy, input dim_t dz,
                                      input logic last_prim, input logic restart_stats);
    prim_item_t it;
    it.az = az;
    it.el = el;
    it.kind = kind;
    it.dim_x = dx;
    it.dim_y = dy;
    it.dim_z = dz;
    it.last_prim = last_prim;
    it.restart_stats = restart_stats;
    return it;
  endfunction

  function automatic dim_t rand_dim();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic elev_t rand_elevation();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sh4000;
      2: return 16'shC000;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic send_prim(input prim_item_t it);
    int gap;
    if (sender_gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      repeat (gap) @(negedge clk) prim_chan.valid <= 1'b0;
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    prim_chan.valid <= 1'b1;
    prim_chan.az <= it.az;
    prim_chan.el <= it.el;
    prim_chan.prim_type <= it.kind;
    prim_chan.dim_x <= it.dim_x;
    prim_chan.dim_y <= it.dim_y;
    prim_chan.dim_z <= it.dim_z;
    prim_chan.last_prim <= it.last_prim;
    prim_chan.restart_stats <= it.restart_stats;
    do @(posedge clk); while (prim_chan.ready !== 1'b1);
    accumulate_primitive(it);
    prims_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic test_primitive_corners();
    send_prim(prim(16'h0000, 16'sh0000, PRIM_BOX, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_prim(prim(16'hFFFF, 16'sh4000, PRIM_BOX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_prim(prim(16'h2000, 16'sh1000, PRIM_BOX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_prim(prim(16'h4000, 16'shC000, PRIM_CYL, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
    send_prim(prim(16'h8000, 16'sh0000, PRIM_CYL, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, 1'b0));
    send_prim(prim(16'hC000, 16'sh2AAA, PRIM_CYL, 16'h1234, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
    send_prim(prim(16'h0001, 16'sh0001, PRIM_SPHERE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_prim(prim(16'h5555, 16'shAAAA, PRIM_SPHERE, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_prim(prim(16'hAAAA, 16'sh5555, PRIM_PANEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_prim(prim(16'h7FFF, 16'sh7FFF, PRIM_PANEL, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
    send_prim(prim(16'h8001, 16'sh8000, PRIM_PANEL, 16'hFFFF, 16'h8000, 16'h0000, 1'b0, 1'b0));
    send_prim(prim(16'h3FFF, 16'shBFFF, PRIM_BOX, 16'h0100, 16'h0200, 16'h0300, 1'b1, 1'b0));
    send_prim(prim(16'h0000, 16'sh4000, PRIM_CYL, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
    send_prim(prim(16'h6000, 16'sh3000, PRIM_SPHERE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
    send_prim(prim(16'hE000, 16'shF000, PRIM_PANEL, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0));
  endtask

  task automatic test_restart_handling();
    send_prim(prim(16'h1000, 16'sh0800, PRIM_BOX, 16'h0400, 16'h0400, 16'h0400, 1'b0, 1'b1));
    send_prim(prim(16'h1000, 16'sh0800, PRIM_PANEL, 16'h0200, 16'h0300, 16'h0000, 1'b1, 1'b1));
    send_prim(prim(16'h9000, 16'shF800, PRIM_SPHERE, 16'h0080, 16'h0000, 16'h0000, 1'b1, 1'b0));
    send_prim(prim(16'h2400, 16'sh1800, PRIM_CYL, 16'h0300, 16'h0500, 16'h0000, 1'b1, 1'b1));
    send_prim(prim(16'hB000, 16'sh0400, PRIM_BOX, 16'h0010, 16'h0020, 16'h0030, 1'b0, 1'b0));
    send_prim(prim(16'hB000, 16'sh0400, PRIM_BOX, 16'h0040, 16'h0050, 16'h0060, 1'b1, 1'b1));
  endtask

  task automatic test_area_saturation();
    for (int k = 0; k < SATURATION_PRIMS; k++) begin
      send_prim(prim(16'h2000, 16'sh1913, PRIM_BOX, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     k == SATURATION_PRIMS - 1, 1'b0));
    end
    send_prim(prim(16'h2000, 16'sh1913, PRIM_PANEL, 16'h0010, 16'h0010, 16'h0000, 1'b1, 1'b0));
  endtask

  task automatic test_random_directions(input int n_items);
    int         sent;
    int         count;
    bit         noisy;
    angle_t     az;
    elev_t      el;
    prim_item_t it;
    sent = 0;
    while (sent < n_items) begin
      az = 16'($urandom);
      el = rand_elevation();
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      noisy = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < count; k++) begin
        it.az = noisy ? 16'($urandom) : az;
        it.el = noisy ? rand_elevation() : el;
        it.kind = prim_t'(2'($urandom_range(0, 3)));
        it.dim_x = rand_dim();
        it.dim_y = rand_dim();
        it.dim_z = rand_dim();
        it.last_prim = (k == count - 1);
        it.restart_stats = it.last_prim ? ($urandom_range(0, 7) == 0)
                                        : (noisy && $urandom_range(0, 1) == 1);
        send_prim(it);
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    test_random_directions(n_items);
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (ready_phase == 4'd0) begin
      if (!receiver_stalls_on) begin
        ready_pattern = 16'hFFFF;
      end else begin
        case ($urandom_range(0, 4))
          0: ready_pattern = 16'hFFFF;
          1: ready_pattern = 16'($urandom) | 16'($urandom);
          2: ready_pattern = 16'($urandom) & 16'($urandom);
          default: ready_pattern = 16'($urandom);
        endcase
      end
    end
    result_chan.ready <= ready_pattern[ready_phase];
    ready_phase = ready_phase + 4'd1;
  end

  always @(posedge clk) begin
    if (rst_n && result_chan.valid === 1'b1 && result_chan.ready === 1'b1) begin
      got.direction_area = result_chan.direction_area;
      got.max_area = result_chan.max_area;
      got.min_area = result_chan.min_area;
      got.area_sum = result_chan.area_sum;
      got.sample_count = result_chan.sample_count;
      if (direction_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected result transaction: area %h max %h min %h sum %h count %0d",
                   $realtime, got.direction_area, got.max_area, got.min_area, got.area_sum,
                   got.sample_count);
        end
      end else begin
        want = direction_results_q.pop_front();
        totals_checked++;
        if (got.direction_area !== want.direction_area || got.max_area !== want.max_area ||
            got.min_area !== want.min_area || got.area_sum !== want.area_sum ||
            got.sample_count !== want.sample_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] direction %0d mismatch (expected/actual):", $realtime,
                     totals_checked);
            $display("  area %h/%h max %h/%h min %h/%h sum %h/%h count %0d/%0d",
                     want.direction_area, got.direction_area, want.max_area, got.max_area,
                     want.min_area, got.min_area, want.area_sum, got.area_sum,
                     want.sample_count, got.sample_count);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d direction results outstanding.", direction_results_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    prim_chan.valid = 1'b0;
    prim_chan.az = '0;
    prim_chan.el = '0;
    prim_chan.prim_type = PRIM_BOX;
    prim_chan.dim_x = '0;
    prim_chan.dim_y = '0;
    prim_chan.dim_z = '0;
    prim_chan.last_prim = 1'b0;
    prim_chan.restart_stats = 1'b0;
    partial_area = '0;
    stat_max = '0;
    stat_min = '1;
    stat_sum = '0;
    stat_count = '0;
    prims_sent = 0;
    restarts_seen = 0;
    saturated_totals = 0;
    burst_left = 0;
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_primitive_corners();
    test_restart_handling();
    test_area_saturation();
    test_random_directions(1120);
    test_back_to_back(200);

    @(negedge clk) prim_chan.valid <= 1'b0;
    while (direction_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d primitives, %0d of them in one saturating direction; checked %0d totals.",
             prims_sent, SATURATION_PRIMS, totals_checked);
    $display("Statistics restarted %0d times; %0d totals hit the 32-bit ceiling; %0d mismatches.",
             restarts_seen, saturated_totals, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
